@@ rtl/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; pulled in by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define MCED_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define MCED_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/mced_pkg.sv @@
// types, codes and constants of the command escape detector
// no dependencies; used by the controller, datapath and top level
package mced_pkg;

  localparam int unsigned LINE_LEN_DEF = 32;

  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_GUARD     = 2'd1,
    OP_DATA_MODE = 2'd2,
    OP_COMMAND   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ECHO = 2'd1,
    KIND_FWD  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CFG_ECHO   = 3'd0,
    CFG_BS     = 3'd1,
    CFG_CR     = 3'd2,
    CFG_ESC    = 3'd3,
    CFG_INACT  = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic       ECHO_RST  = 1'b1;
  localparam logic [6:0] BS_RST    = 7'd8;
  localparam logic [7:0] CR_RST    = 8'd13;
  localparam logic [7:0] ESC_RST   = 8'd43;
  localparam logic       INACT_RST = 1'b0;

  // character constants
  localparam logic [6:0] CASE_MASK  = 7'h5f;
  localparam int unsigned CASE_BIT  = 5;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_T     = 7'h54;
  localparam logic [6:0] CHAR_SLASH = 7'h2f;
  localparam logic [2:0] ESC_RUN    = 3'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    kind_e      out_kind;
    logic [7:0] out_byte;
    logic       t_after;
    logic       prefix_found;
    logic [7:0] prefix_first;
    logic       line_char_valid;
    logic [6:0] line_char;
    logic       line_last;
    logic       escape_found;
    logic       inactivity_hangup;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic commit;
    logic run_start;
    logic load_single;
    logic load_run;
    logic run_adv;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_run;
    logic has_result;
    logic run_last;
  } stat_t;

endpackage

@@ rtl/mced_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mced_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mced_ctrl.sv @@
// controller: request handshake, item sequencing and output valid
// depends on mced_pkg
module mced_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  mced_pkg::stat_t stat_i,
  output mced_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RUN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_run) begin
          cmd_o.commit    = 1'b1;
          cmd_o.run_start = 1'b1;
          state_d         = S_RUN;
        end else if (stat_i.has_result) begin
          if (out_free) begin
            cmd_o.commit      = 1'b1;
            cmd_o.load_single = 1'b1;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_RUN: begin
        if (out_free) begin
          cmd_o.load_run = 1'b1;
          if (stat_i.run_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.run_adv = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_single || cmd_o.load_run) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/mced_dp.sv @@
// datapath: registers, mode and line state, line buffers, run counter, output register
// depends on mced_pkg and mced_ram
module mced_dp #(
  parameter int unsigned LINE_LEN = mced_pkg::LINE_LEN_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [7:0]      cfg_data_i,
  input  mced_pkg::in_t   in_req_i,
  input  mced_pkg::cmd_t  cmd_i,
  output mced_pkg::stat_t stat_o,
  output mced_pkg::res_t  out_res_o
);

  localparam int unsigned IW    = $clog2(LINE_LEN);
  localparam int unsigned LW    = $clog2(LINE_LEN + 1);
  localparam int unsigned AW    = IW + 1;
  localparam int unsigned DEPTH = 2 * (2 ** IW);

  // configuration
  logic       echo_q, inact_q;
  logic [6:0] bs_q;
  logic [7:0] cr_q, esc_char_q;

  // item and mode state
  mced_pkg::in_t item_q;
  logic          command_q, command_d;
  logic          prefix_q, prefix_d;
  logic [7:0]    first_q, first_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] saved_len_q, saved_len_d;
  logic          bank_q, bank_d;
  logic          guard_q, guard_d;
  logic [2:0]    esc_cnt_q, esc_cnt_d;

  // run sequencer
  logic [LW-1:0]  run_n_q, k_q, k_next;
  logic           src_bank_q;
  mced_pkg::res_t head_q;
  mced_pkg::res_t out_q;

  // decode of the latched item
  mced_pkg::res_t single;
  logic           is_run, run_src, wr_en;
  logic [LW-1:0]  run_len;
  logic [6:0]     raw;
  logic           run_last;
  logic [AW-1:0]  raddr;
  logic           re;
  logic [6:0]     rdata;
  mced_pkg::res_t run_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q     <= mced_pkg::ECHO_RST;
      bs_q       <= mced_pkg::BS_RST;
      cr_q       <= mced_pkg::CR_RST;
      esc_char_q <= mced_pkg::ESC_RST;
      inact_q    <= mced_pkg::INACT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mced_pkg::CFG_ECHO:  echo_q     <= cfg_data_i[0];
        mced_pkg::CFG_BS:    bs_q       <= cfg_data_i[6:0];
        mced_pkg::CFG_CR:    cr_q       <= cfg_data_i;
        mced_pkg::CFG_ESC:   esc_char_q <= cfg_data_i;
        mced_pkg::CFG_INACT: inact_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign raw = item_q.in_byte[6:0];

  always_comb begin
    single      = '0;
    is_run      = 1'b0;
    run_src     = bank_q;
    run_len     = len_q;
    wr_en       = 1'b0;
    command_d   = command_q;
    prefix_d    = prefix_q;
    first_d     = first_q;
    len_d       = len_q;
    saved_len_d = saved_len_q;
    bank_d      = bank_q;
    guard_d     = guard_q;
    esc_cnt_d   = esc_cnt_q;
    case (mced_pkg::op_e'(item_q.opcode))
      mced_pkg::OP_BYTE: begin
        if (command_q) begin
          if (echo_q) begin
            single.out_kind = mced_pkg::KIND_ECHO;
            single.out_byte = item_q.in_byte;
          end
          if (prefix_q) begin
            if (raw == bs_q) begin
              if (len_q == '0) begin
                single.t_after = echo_q;
              end else begin
                len_d = len_q - 1'b1;
              end
            end else if (item_q.in_byte == cr_q) begin
              // line done: the line bank becomes the saved bank
              is_run      = 1'b1;
              saved_len_d = len_q;
              len_d       = '0;
              first_d     = '0;
              prefix_d    = 1'b0;
              bank_d      = !bank_q;
            end else if (len_q < LW'(LINE_LEN)) begin
              wr_en = 1'b1;
              len_d = len_q + 1'b1;
            end
          end else if (first_q != '0) begin
            if ((raw & mced_pkg::CASE_MASK) == mced_pkg::CHAR_T &&
                first_q[mced_pkg::CASE_BIT] == raw[mced_pkg::CASE_BIT]) begin
              prefix_d            = 1'b1;
              single.prefix_found = 1'b1;
              single.prefix_first = first_q;
            end else if (raw == mced_pkg::CHAR_SLASH) begin
              // replay the saved bank; line contents past the saved length are never used
              is_run   = 1'b1;
              run_src  = !bank_q;
              run_len  = saved_len_q;
              len_d    = '0;
              prefix_d = 1'b0;
            end else if ((raw & mced_pkg::CASE_MASK) != mced_pkg::CHAR_A) begin
              first_d = '0;
            end
          end else if ((raw & mced_pkg::CASE_MASK) == mced_pkg::CHAR_A) begin
            first_d = item_q.in_byte;
          end
        end else begin
          single.out_kind = mced_pkg::KIND_FWD;
          single.out_byte = item_q.in_byte;
          if (guard_q) begin
            if (item_q.in_byte == esc_char_q && esc_cnt_q < mced_pkg::ESC_RUN) begin
              esc_cnt_d = esc_cnt_q + 1'b1;
            end else begin
              guard_d   = 1'b0;
              esc_cnt_d = '0;
            end
          end
        end
      end
      mced_pkg::OP_GUARD: begin
        if (guard_q && esc_cnt_q == mced_pkg::ESC_RUN) begin
          command_d           = 1'b1;
          guard_d             = 1'b0;
          esc_cnt_d           = '0;
          single.escape_found = 1'b1;
        end else if (!guard_q) begin
          guard_d = 1'b1;
        end else if (esc_cnt_q != '0) begin
          guard_d   = 1'b0;
          esc_cnt_d = '0;
        end else if (inact_q) begin
          command_d                = 1'b1;
          guard_d                  = 1'b0;
          esc_cnt_d                = '0;
          single.inactivity_hangup = 1'b1;
        end
      end
      mced_pkg::OP_DATA_MODE: begin
        command_d = 1'b0;
      end
      default: begin
        command_d = 1'b1;
        guard_d   = 1'b0;
        esc_cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_q   <= 1'b1;
      prefix_q    <= 1'b0;
      first_q     <= '0;
      len_q       <= '0;
      saved_len_q <= '0;
      bank_q      <= 1'b0;
      guard_q     <= 1'b0;
      esc_cnt_q   <= '0;
    end else if (cmd_i.commit) begin
      command_q   <= command_d;
      prefix_q    <= prefix_d;
      first_q     <= first_d;
      len_q       <= len_d;
      saved_len_q <= saved_len_d;
      bank_q      <= bank_d;
      guard_q     <= guard_d;
      esc_cnt_q   <= esc_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_n_q <= '0;
      k_q     <= '0;
    end else if (cmd_i.run_start) begin
      run_n_q <= run_len;
      k_q     <= '0;
    end else if (cmd_i.run_adv) begin
      k_q <= k_next;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_req_i;
    end
    if (cmd_i.run_start) begin
      src_bank_q <= run_src;
      head_q     <= single;
    end
    if (cmd_i.load_single) begin
      out_q <= single;
    end else if (cmd_i.load_run) begin
      out_q <= run_res;
    end
  end

  assign k_next   = k_q + 1'b1;
  assign run_last = (run_n_q == '0) || (k_next == run_n_q);

  assign raddr = cmd_i.run_start ? {run_src, IW'(0)} : {src_bank_q, k_next[IW-1:0]};
  assign re    = cmd_i.run_start || cmd_i.run_adv;

  mced_ram #(
    .WIDTH (7),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en && cmd_i.commit),
    .waddr_i ({bank_q, len_q[IW-1:0]}),
    .wdata_i (raw),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    run_res                 = (k_q == '0) ? head_q : '0;
    run_res.line_char_valid = (run_n_q != '0);
    run_res.line_char       = (run_n_q != '0) ? rdata : '0;
    run_res.line_last       = run_last;
  end

  assign stat_o.is_run     = is_run;
  assign stat_o.has_result = !is_run && ((single.out_kind != mced_pkg::KIND_NONE) ||
                             single.t_after || single.prefix_found ||
                             single.escape_found || single.inactivity_hangup);
  assign stat_o.run_last   = run_last;
  assign out_res_o         = out_q;

endmodule

@@ rtl/modem_command_escape_detector.sv @@
// top level of the modem command and escape detector
// depends on mced_pkg, mced_ctrl, mced_dp and assert_macros.svh
//
// usage:
//  - input channel (in_valid_i / in_stall_o / in_req_i): one request is an
//    opcode and a terminal byte; it is taken when valid is high and stall low
//  - output channel (out_valid_o / out_stall_i / out_res_o): result items,
//    held stable while the receiver stalls
//  - config port (cfg_we_i / cfg_idx_i / cfg_data_i): write-only, one register
//    per edge with the enable high; write only while the block is idle
//  - a request is accepted while idle, then decoded and committed; the input
//    stays stalled at least until it commits, which waits on a stalled output
//  - a line run (carriage return, or slash after an 'A') gives max(n,1)
//    results, one per cycle while the output is not stalled, from the line
//    ram's single read port; the input is stalled until the last one is loaded
//  - the output register frees the input side: a request is accepted while a
//    result still waits; a stalled output holds the decode until it drains
//  - reset puts the block in command mode with default registers, empty line
//    and saved line, and no escape pending; the line ram needs no clearing
//  - the line ram holds two banks that swap roles when a line completes
module modem_command_escape_detector #(
  parameter int unsigned LINE_LEN = mced_pkg::LINE_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mced_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mced_pkg::res_t out_res_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i
);

  mced_pkg::cmd_t  cmd;
  mced_pkg::stat_t stat;

  // controller: handshake and sequencing
  mced_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: state, line buffers and result assembly
  mced_dp #(
    .LINE_LEN (LINE_LEN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_res_o  (out_res_o)
  );

`include "assert_macros.svh"

  // an accepted request always holds off the input in the cycle after it
  `MCED_ASSERT_NEXT(a_accept_then_stall, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // the run sequencer only steps while the input is held off
  `MCED_ASSERT_NOW(a_run_stalls_input, clk_i, rst_ni, cmd.run_adv, in_stall_o)
  // a request is either a line run or at most one single result
  `MCED_ASSERT_NOW(a_run_or_single, clk_i, rst_ni, stat.is_run, !stat.has_result)

endmodule
